// ===== design/bfpa_pkg.sv =====
package bfpa_pkg;

    localparam int MAX_BLOCKS = 8;
    localparam int SIZE_BITS  = 16;

    localparam int ID_W    = 8;
    localparam int REQ_W   = 2;
    localparam int ST_W    = 2;
    localparam int FAIL_W  = 8;
    localparam int FRAG_W  = 19;
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int TOTAL_W = SIZE_BITS + $clog2(MAX_BLOCKS);
    localparam int WORD_W  = ID_W + SIZE_BITS;
    localparam int WIDE_W  = (TOTAL_W > FRAG_W) ? TOTAL_W : FRAG_W;

    localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};
    localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_MAPPED  = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_TFULL   = 2'd2;
    localparam logic [ST_W-1:0] ST_DONE    = 2'd3;

    // best candidate found by a table scan
    typedef struct packed {
        logic                 found;
        logic [IDX_W-1:0]     idx;
        logic [SIZE_BITS-1:0] size;
        logic [ID_W-1:0]      id;
    } scan_res_t;

    function automatic logic [FRAG_W-1:0] sat_frag(input logic [TOTAL_W-1:0] total);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(total);
        if (wide > WIDE_W'(FRAG_MAX))
            return FRAG_MAX;
        else
            return FRAG_W'(wide);
    endfunction

endpackage

// ===== design/bfpa_ram.sv =====
module bfpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== design/bfpa_scan.sv =====
module bfpa_scan (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bfpa_pkg::CNT_W-1:0]     count,
    input  logic [bfpa_pkg::SIZE_BITS-1:0] req_size,
    input  logic [bfpa_pkg::MAX_BLOCKS-1:0] full,
    input  logic [bfpa_pkg::WORD_W-1:0]    rd_data,
    output logic                           rd_en,
    output logic [bfpa_pkg::IDX_W-1:0]     rd_addr,
    output logic                           done,
    output bfpa_pkg::scan_res_t            res
);
    import bfpa_pkg::*;

    logic                 active_reg, active_next;
    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 vld_reg, vld_next;
    logic [IDX_W-1:0]     vidx_reg, vidx_next;
    scan_res_t            best_reg, best_next;

    logic [SIZE_BITS-1:0] cand_size;
    logic [ID_W-1:0]      cand_id;
    logic                 take;

    assign rd_en   = active_reg && (issue_reg < count);
    assign rd_addr = issue_reg[IDX_W-1:0];
    assign done    = active_reg && (issue_reg == count) && !vld_reg;
    assign res     = best_reg;

    assign cand_size = rd_data[SIZE_BITS-1:0];
    assign cand_id   = rd_data[WORD_W-1 -: ID_W];

    // smallest fitting remainder; strict < keeps the earliest entry on ties
    assign take = vld_reg && !full[vidx_reg] && (cand_size >= req_size)
                  && (!best_reg.found || (cand_size < best_reg.size));

    always_comb
    begin
        active_next = active_reg;
        issue_next  = issue_reg;
        vld_next    = rd_en;
        vidx_next   = rd_addr;
        best_next   = best_reg;
        if (start)
        begin
            active_next     = 1'b1;
            issue_next      = '0;
            vld_next        = 1'b0;
            best_next.found = 1'b0;
        end
        else
        begin
            if (rd_en)
                issue_next = issue_reg + CNT_W'(1);
            if (take)
            begin
                best_next.found = 1'b1;
                best_next.idx   = vidx_reg;
                best_next.size  = cand_size;
                best_next.id    = cand_id;
            end
            if (done)
                active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            issue_reg  <= '0;
            vld_reg    <= 1'b0;
            best_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            issue_reg  <= issue_next;
            vld_reg    <= vld_next;
            best_reg   <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vidx_reg <= vidx_next;
    end

endmodule

// ===== design/best_fit_partition_allocator.sv =====
// Best-fit partition allocator.
// Input channel (in_valid/in_ready) carries one request per transaction:
// clear table, load block (id, size), allocate (size) or report fragmentation.
// Output channel (out_valid/out_ready) returns exactly one result transaction
// per request: status, chosen block id, unplaced request count, and on a
// report the external fragmentation with its valid flag.
// Block sizes and ids live in a small synchronous RAM; full flags and the
// counters live in flops. Requests are handled one at a time.
// An accepted request passes through S_EXEC and S_EMIT before out_valid. An
// allocate starts the scan in S_EXEC, waits in S_SCAN (one RAM read per loaded
// block, the registered RAM read data, then the scan flags done) and writes
// back in S_WB before S_EMIT; on an empty table the scan reads nothing.
// in_ready returns together with the registered result, so a new request is
// taken only once the previous result has entered the output register.
// Reset (rst_n low, asynchronous) empties the table and clears all counters;
// the RAM contents are not cleared, only loaded entries are ever read.
// A stalled receiver holds the result in the output register; the block still
// takes and works the next request, and holds its result until the output
// register frees up.
module best_fit_partition_allocator (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bfpa_pkg::REQ_W-1:0] req_type,
    input  logic [bfpa_pkg::ID_W-1:0]  item_id,
    input  logic [15:0]                item_size,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [bfpa_pkg::ST_W-1:0]  status,
    output logic [bfpa_pkg::ID_W-1:0]  block_id,
    output logic [bfpa_pkg::FAIL_W-1:0] unallocated_count,
    output logic [bfpa_pkg::FRAG_W-1:0] ext_frag,
    output logic                      frag_valid
);
    import bfpa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WB,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    // latched request
    logic [REQ_W-1:0]      op_reg, op_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [SIZE_BITS-1:0]  size_reg, size_next;

    // table bookkeeping
    logic [MAX_BLOCKS-1:0] full_reg, full_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [FAIL_W-1:0]     failed_reg, failed_next;
    logic [TOTAL_W-1:0]    total_reg, total_next;

    // result waiting for the output register
    logic [ST_W-1:0]       rstat_reg, rstat_next;
    logic [ID_W-1:0]       rid_reg, rid_next;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [ST_W-1:0]       status_reg, status_next;
    logic [ID_W-1:0]       block_id_reg, block_id_next;
    logic [FAIL_W-1:0]     unalloc_reg, unalloc_next;
    logic [FRAG_W-1:0]     frag_reg, frag_next;
    logic                  fvalid_reg, fvalid_next;

    // RAM ports
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  scan_start;
    logic                  scan_done;
    scan_res_t             scan_res;

    bfpa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Reads happen only in S_SCAN, writes only in S_EXEC and S_WB, so the
    // sequencing itself keeps a read from ever overlapping a pending write.
    bfpa_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .count    (count_reg),
        .req_size (size_reg),
        .full     (full_reg),
        .rd_data  (ram_rdata),
        .rd_en    (ram_re),
        .rd_addr  (ram_raddr),
        .done     (scan_done),
        .res      (scan_res)
    );

    assign in_ready          = (state_reg == S_IDLE);
    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign block_id          = block_id_reg;
    assign unallocated_count = unalloc_reg;
    assign ext_frag          = frag_reg;
    assign frag_valid        = fvalid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        size_next      = size_reg;
        full_next      = full_reg;
        count_next     = count_reg;
        failed_next    = failed_reg;
        total_next     = total_reg;
        rstat_next     = rstat_reg;
        rid_next       = rid_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        block_id_next  = block_id_reg;
        unalloc_next   = unalloc_reg;
        frag_next      = frag_reg;
        fvalid_next    = fvalid_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        scan_start     = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = req_type;
                    id_next    = item_id;
                    size_next  = SIZE_BITS'(item_size);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rstat_next = ST_DONE;
                rid_next   = '0;
                state_next = S_EMIT;
                unique case (op_reg)
                    REQ_CLEAR:
                    begin
                        full_next   = '0;
                        count_next  = '0;
                        failed_next = '0;
                        total_next  = '0;
                    end
                    REQ_LOAD:
                    begin
                        if (count_reg >= CNT_W'(MAX_BLOCKS))
                            rstat_next = ST_TFULL;
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = count_reg[IDX_W-1:0];
                            ram_wdata = {id_reg, size_reg};
                            full_next[count_reg[IDX_W-1:0]] = 1'b0;
                            count_next = count_reg + CNT_W'(1);
                            total_next = total_reg + TOTAL_W'(size_reg);
                        end
                    end
                    REQ_ALLOC:
                    begin
                        scan_start = 1'b1;
                        state_next = S_SCAN;
                    end
                    REQ_REPORT:
                    begin
                        rstat_next = ST_DONE;
                    end
                    default:
                    begin
                        rstat_next = ST_DONE;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (scan_done)
                    state_next = S_WB;
            end
            S_WB:
            begin
                if (scan_res.found)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = scan_res.idx;
                    ram_wdata  = {scan_res.id, scan_res.size - size_reg};
                    if (scan_res.size == size_reg)
                        full_next[scan_res.idx] = 1'b1;
                    total_next = total_reg - TOTAL_W'(size_reg);
                    rstat_next = ST_MAPPED;
                    rid_next   = scan_res.id;
                end
                else
                begin
                    if (failed_reg != FAIL_MAX)
                        failed_next = failed_reg + FAIL_W'(1);
                    rstat_next = ST_NOFIT;
                    rid_next   = '0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // wait here while the previous result is still unclaimed
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rstat_reg;
                    block_id_next  = rid_reg;
                    unalloc_next   = failed_reg;
                    if (op_reg == REQ_REPORT)
                    begin
                        frag_next   = sat_frag(total_reg);
                        fvalid_next = (failed_reg != '0);
                    end
                    else
                    begin
                        frag_next   = '0;
                        fvalid_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_reg      <= '0;
            count_reg     <= '0;
            failed_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            full_reg      <= full_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        id_reg       <= id_next;
        size_reg     <= size_next;
        rstat_reg    <= rstat_next;
        rid_reg      <= rid_next;
        status_reg   <= status_next;
        block_id_reg <= block_id_next;
        unalloc_reg  <= unalloc_next;
        frag_reg     <= frag_next;
        fvalid_reg   <= fvalid_next;
    end

    // table never holds more entries than it has room for
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table size");

    // only loaded entries can be marked full
    assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg >> count_reg) == '0)
        else $error("full flag set on an unloaded entry");

    // a chosen block always covers the request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) && scan_done && scan_res.found
        |-> scan_res.size >= size_reg)
        else $error("scan picked a block smaller than the request");

    // fragmentation fields only carry data on a report
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_DONE) |-> (ext_frag == '0) && !frag_valid)
        else $error("fragmentation reported on a non-report result");

endmodule

// ===== tb/best_fit_partition_allocator_test.sv =====
module best_fit_partition_allocator_test;

    import bfpa_pkg::*;

    // One result transaction as it leaves the block.
    typedef struct {
        logic [ST_W-1:0]   status;
        logic [ID_W-1:0]   block_id;
        logic [FAIL_W-1:0] miss_count;
        logic [FRAG_W-1:0] frag;
        logic              frag_valid;
    } alloc_result_t;

    // Partition table mirror plus the queue of results still owed by the block.
    class alloc_scoreboard;
        logic [SIZE_BITS-1:0] part_size  [MAX_BLOCKS];
        logic [ID_W-1:0]      part_owner [MAX_BLOCKS];
        bit                   part_full  [MAX_BLOCKS];
        int unsigned          part_count;
        int unsigned          miss_total;
        int unsigned          free_sum;
        alloc_result_t        due_results[$];
        int unsigned          errors;
        int unsigned          seen_status[4];
        int unsigned          frag_flagged;
        bit                   miss_saturated;

        function void clear_table();
            part_count = 0;
            miss_total = 0;
            free_sum   = 0;
            foreach (part_full[i])
                part_full[i] = 0;
        endfunction

        // Work out the result of one accepted request and queue it.
        function void place_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                    logic [15:0] size);
            alloc_result_t        r;
            logic [SIZE_BITS-1:0] want;
            bit                   found;
            int                   best;
            want         = SIZE_BITS'(size);
            r.status     = ST_DONE;
            r.block_id   = '0;
            r.frag       = '0;
            r.frag_valid = 1'b0;
            found        = 0;
            best         = 0;
            case (kind)
                REQ_CLEAR: clear_table();
                REQ_LOAD:
                begin
                    if (part_count >= MAX_BLOCKS)
                        r.status = ST_TFULL;
                    else
                    begin
                        part_size[part_count]  = want;
                        part_owner[part_count] = id;
                        part_full[part_count]  = 0;
                        part_count++;
                        free_sum += want;
                    end
                end
                REQ_ALLOC:
                begin
                    // smallest fit wins; strict compare keeps the earliest on a tie
                    for (int i = 0; i < part_count; i++)
                        if (!part_full[i] && part_size[i] >= want)
                            if (!found || part_size[i] < part_size[best])
                            begin
                                best  = i;
                                found = 1;
                            end
                    if (found)
                    begin
                        part_size[best] -= want;
                        free_sum        -= want;
                        if (part_size[best] == 0)
                            part_full[best] = 1;
                        r.status   = ST_MAPPED;
                        r.block_id = part_owner[best];
                    end
                    else
                    begin
                        if (miss_total < FAIL_MAX)
                            miss_total++;
                        r.status = ST_NOFIT;
                    end
                end
                default:
                begin
                    r.frag       = (free_sum > FRAG_MAX) ? FRAG_MAX : FRAG_W'(free_sum);
                    r.frag_valid = (miss_total != 0);
                end
            endcase
            r.miss_count = FAIL_W'(miss_total);
            due_results.push_back(r);
        endfunction

        function void check_result(alloc_result_t got);
            alloc_result_t exp;
            if (due_results.size() == 0)
            begin
                $error("result transaction with no request outstanding");
                errors++;
                return;
            end
            exp = due_results.pop_front();
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d, got %0d", exp.status, got.status);
                errors++;
            end
            if (got.block_id !== exp.block_id)
            begin
                $error("block_id: expected %0d, got %0d", exp.block_id, got.block_id);
                errors++;
            end
            if (got.miss_count !== exp.miss_count)
            begin
                $error("unallocated_count: expected %0d, got %0d",
                       exp.miss_count, got.miss_count);
                errors++;
            end
            if (got.frag !== exp.frag)
            begin
                $error("ext_frag: expected %0d, got %0d", exp.frag, got.frag);
                errors++;
            end
            if (got.frag_valid !== exp.frag_valid)
            begin
                $error("frag_valid: expected %0d, got %0d", exp.frag_valid, got.frag_valid);
                errors++;
            end
            seen_status[exp.status]++;
            if (exp.frag_valid)
                frag_flagged++;
            if (exp.miss_count == FAIL_MAX)
                miss_saturated = 1;
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [REQ_W-1:0]  req_type = REQ_CLEAR;
    logic [ID_W-1:0]   item_id = '0;
    logic [15:0]       item_size = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [ST_W-1:0]   status;
    logic [ID_W-1:0]   block_id;
    logic [FAIL_W-1:0] unallocated_count;
    logic [FRAG_W-1:0] ext_frag;
    logic              frag_valid;

    alloc_scoreboard sb = new();
    int unsigned     requests_sent;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;

    localparam int unsigned TOTAL_REQUESTS = 1950;

    best_fit_partition_allocator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .item_id           (item_id),
        .item_size         (item_size),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .block_id          (block_id),
        .unallocated_count (unallocated_count),
        .ext_frag          (ext_frag),
        .frag_valid        (frag_valid)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle mix by progress: sender sparse / receiver heavy, then swapped,
    // then a final stretch with both sides running flat out.
    function void update_idle_mix();
        if (requests_sent < TOTAL_REQUESTS / 3)
        begin
            send_idle_pct = 9;
            recv_idle_pct = 62;
        end
        else if (requests_sent < 2 * TOTAL_REQUESTS / 3)
        begin
            send_idle_pct = 62;
            recv_idle_pct = 9;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endfunction

    // Drive one request transaction. Valid is left high after acceptance so
    // back-to-back requests never see a low/high pair in the same step; it
    // drops only when the sender decides to idle.
    task automatic send_request(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                                logic [15:0] size);
        update_idle_mix();
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        item_id   <= id;
        item_size <= size;
        do
            @(posedge clk);
        while (!in_ready);
        sb.place_request(kind, id, size);
        requests_sent++;
    endtask

    // Receiver: random backpressure, every accepted result goes to the scoreboard.
    initial
    begin
        alloc_result_t got;
        forever
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                got.status     = status;
                got.block_id   = block_id;
                got.miss_count = unallocated_count;
                got.frag       = ext_frag;
                got.frag_valid = frag_valid;
                sb.check_result(got);
            end
        end
    end

    // Random size drawn to the flavor of the current sequence: narrow sizes,
    // full-range sizes, or a handful of repeated values to force ties.
    function automatic logic [15:0] pick_size(int unsigned flavor);
        logic [15:0] picks [5];
        picks = '{16'd0, 16'd64, 16'd128, 16'd256, 16'hFFFF};
        case (flavor)
            0:       return 16'($urandom_range(0, 511));
            1:       return 16'($urandom_range(0, 65535) >> $urandom_range(0, 10));
            default: return picks[$urandom_range(0, 4)];
        endcase
    endfunction

    // One well-formed episode: usually a clear, then a batch of loads (sometimes
    // past capacity), then allocations mixed with reports and a little noise.
    task automatic run_episode();
        int unsigned flavor;
        int unsigned loads;
        int unsigned allocs;
        int unsigned roll;
        flavor = $urandom_range(0, 2);
        loads  = $urandom_range(1, MAX_BLOCKS + 2);
        allocs = $urandom_range(1, 16);
        if ($urandom_range(99) < 85)
            send_request(REQ_CLEAR, ID_W'($urandom), 16'($urandom));
        repeat (loads)
            send_request(REQ_LOAD, ID_W'($urandom), pick_size(flavor));
        repeat (allocs)
        begin
            roll = $urandom_range(99);
            if (roll < 15)
                send_request(REQ_REPORT, ID_W'($urandom), 16'($urandom));
            else if (roll < 20)
                send_request(REQ_W'($urandom), ID_W'($urandom), 16'($urandom));
            else
                send_request(REQ_ALLOC, ID_W'($urandom),
                             ($urandom_range(99) < 10) ? 16'($urandom) : pick_size(flavor));
        end
        send_request(REQ_REPORT, ID_W'($urandom), 16'($urandom));
    endtask

    initial
    begin
        sb.clear_table();
        update_idle_mix();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table behavior first
        send_request(REQ_REPORT, 8'd0,   16'd0);      // nothing loaded, no misses
        send_request(REQ_ALLOC,  8'd9,   16'd0);      // zero-size request, empty table
        send_request(REQ_REPORT, 8'd255, 16'hFFFF);   // frag flag now set
        send_request(REQ_CLEAR,  8'hFF,  16'hFFFF);   // clear also drops the miss count
        send_request(REQ_LOAD,   8'd255, 16'hFFFF);   // largest block
        send_request(REQ_LOAD,   8'd0,   16'd0);      // zero-size block, stored not full
        send_request(REQ_LOAD,   8'h5A,  16'd300);
        send_request(REQ_LOAD,   8'hA5,  16'd300);    // tie with the previous load
        send_request(REQ_LOAD,   8'd1,   16'd100);
        send_request(REQ_ALLOC,  8'd7,   16'd0);      // lands on the empty block, marks it full
        send_request(REQ_ALLOC,  8'd8,   16'd300);    // tie goes to the earlier load
        send_request(REQ_ALLOC,  8'd9,   16'd250);
        send_request(REQ_ALLOC,  8'd10,  16'hFFFF);   // exact fit on the largest block
        send_request(REQ_ALLOC,  8'd11,  16'hFFFF);   // nothing left that big
        send_request(REQ_REPORT, 8'd0,   16'd0);
        send_request(REQ_LOAD,   8'd2,   16'd40000);
        send_request(REQ_LOAD,   8'd3,   16'd1);
        send_request(REQ_LOAD,   8'd4,   16'hAAAA);   // table now holds eight blocks
        send_request(REQ_LOAD,   8'd5,   16'h5555);   // over capacity
        send_request(REQ_ALLOC,  8'd12,  16'd1);      // smallest fit among leftovers
        send_request(REQ_REPORT, 8'd0,   16'd0);
        send_request(REQ_CLEAR,  8'd0,   16'd0);
        send_request(REQ_REPORT, 8'd0,   16'd0);

        // Drive the miss counter past its ceiling on an empty table.
        send_request(REQ_CLEAR, 8'd0, 16'd0);
        repeat (265)
            send_request(REQ_ALLOC, ID_W'($urandom), 16'($urandom));
        send_request(REQ_REPORT, 8'd0, 16'd0);

        while (requests_sent < TOTAL_REQUESTS)
            run_episode();
        in_valid <= 1'b0;

        // Drain, then allow for the longest allocate latency before closing.
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (4 * (MAX_BLOCKS + 6)) @(posedge clk);

        $display("Covered %0d requests: %0d mapped, %0d no-fit, %0d table-full, %0d done.",
                 requests_sent, sb.seen_status[ST_MAPPED], sb.seen_status[ST_NOFIT],
                 sb.seen_status[ST_TFULL], sb.seen_status[ST_DONE]);
        $display("Reports with fragmentation flagged: %0d; miss counter saturated: %0d.",
                 sb.frag_flagged, sb.miss_saturated);
        if (sb.errors == 0 && sb.due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: far above the slowest legal run.
    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
